/* sv/rdsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsc_pkg
// Shared widths, types and helpers of the radix digit string converter.
// ----------------------------------------------------------------------------
package rdsc_pkg;

  localparam int VALUE_BITS  = 31;
  localparam int DIGIT_DEPTH = 32;
  localparam int BASE_W      = 6;
  localparam int CHAR_W      = 7;
  localparam int DIGIT_W     = 6;
  localparam int IDX_W       = $clog2(DIGIT_DEPTH);
  localparam int CNT_W       = $clog2(DIGIT_DEPTH + 1);
  localparam int BIT_CNT_W   = $clog2(VALUE_BITS);

  localparam logic [BASE_W-1:0] BASE_MIN      = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX      = BASE_W'(36);
  localparam logic [DIGIT_W-1:0] LETTER_LIMIT = DIGIT_W'(10);
  localparam logic [CHAR_W-1:0] ZERO_CHAR     = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] LETTER_OFFSET = CHAR_W'(55);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [BASE_W-1:0]     base_t;
  typedef logic [DIGIT_W-1:0]    digit_t;
  typedef logic [CHAR_W-1:0]     char_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_EMIT
  } state_t;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic   done;
    value_t quo;
    digit_t rem;
  } div_stat_t;

  function automatic base_t base_clamp(input base_t b);
    base_t r;
    r = b;
    if (b < BASE_MIN) r = BASE_MIN;
    if (b > BASE_MAX) r = BASE_MAX;
    return r;
  endfunction

  function automatic char_t to_ascii(input digit_t d);
    char_t r;
    if (d < LETTER_LIMIT) r = CHAR_W'(d) + ZERO_CHAR;
    else                  r = CHAR_W'(d) + LETTER_OFFSET;
    return r;
  endfunction

endpackage

/* sv/rdsc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsc_in_if / rdsc_out_if
// Valid/ready channels of the converter: value items in, characters out.
// ----------------------------------------------------------------------------
interface rdsc_in_if;
  logic                              valid;
  logic                              ready;
  logic [rdsc_pkg::VALUE_BITS-1:0]   value;
  logic [rdsc_pkg::BASE_W-1:0]       base;

  modport source (output valid, output value, output base, input ready);
  modport sink   (input valid, input value, input base, output ready);
endinterface

interface rdsc_out_if;
  logic                          valid;
  logic                          ready;
  logic [rdsc_pkg::CHAR_W-1:0]   digit_char;
  logic                          last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

/* sv/rdsc_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsc_divider
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rdsc_divider (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  rdsc_pkg::value_t       dividend,
  input  rdsc_pkg::base_t        divisor,
  output rdsc_pkg::div_stat_t    stat
);
  import rdsc_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  value_t               quo_r, quo_nxt;
  digit_t               rem_r, rem_nxt;
  logic [DIGIT_W:0]     rem_sh;
  logic                 ge;

  // Shift in the next dividend bit, subtract the divisor when it fits.
  assign rem_sh = {rem_r, quo_r[VALUE_BITS-1]};
  assign ge     = rem_sh >= {1'b0, divisor};

  always_comb begin
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    bit_cnt_nxt = bit_cnt_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    if (start) begin
      busy_nxt    = 1'b1;
      bit_cnt_nxt = '0;
      quo_nxt     = dividend;
      rem_nxt     = '0;
    end else if (busy_r) begin
      quo_nxt     = {quo_r[VALUE_BITS-2:0], ge};
      rem_nxt     = ge ? DIGIT_W'(rem_sh - {1'b0, divisor}) : DIGIT_W'(rem_sh);
      bit_cnt_nxt = bit_cnt_r + BIT_CNT_W'(1);
      if (bit_cnt_r == BIT_CNT_W'(VALUE_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_cnt_r <= bit_cnt_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
  end

  assign stat.done = done_r;
  assign stat.quo  = quo_r;
  assign stat.rem  = rem_r;

  a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> {1'b0, rem_r} < {1'b0, divisor})
    else $error("remainder not below divisor");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("done without a running division");

  a_busy_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && done_r))
    else $error("divider busy and done together");

endmodule

/* sv/radix_digit_string_converter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_string_converter
// Converts an unsigned integer into ASCII digits of a base from 2 to 36.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  takes one item: value (31 bits) and base (2..36; values outside
//          are clamped). in_ch.ready is high only while the block is idle.
//   out_ch returns one ASCII character per digit, most significant digit
//          first; last marks the least significant character. A value of
//          zero produces no characters.
// Operation:
//   Each digit costs one bit-serial division in the shared divider;
//   each character then takes a stack read, then an output. The worst
//   case is base 2 with 31 digits, plus the time the receiver holds off.
// Reset:
//   Synchronous, active low; returns to idle with an empty digit stack.
// Stalls:
//   A character waits in the output register until out_ch.ready; the
//   stack pop resumes once it has been taken.
// ----------------------------------------------------------------------------
module radix_digit_string_converter (
  input  logic       clk,
  input  logic       rst_n,
  rdsc_in_if.sink    in_ch,
  rdsc_out_if.source out_ch
);
  import rdsc_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  base_t            base_r;
  digit_t           rd_data_r;
  logic             last_r;

  div_stat_t        div_stat;
  logic             div_start;
  value_t           div_dividend;

  logic             in_acc;
  logic             push;
  logic             pop;
  logic             div_end;
  logic [CNT_W-1:0] cnt_dec;

  // Digit stack; entries are always written before they are read.
  digit_t           stack_mem [DIGIT_DEPTH];

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cnt_dec = cnt_r - CNT_W'(1);
  // Stop dividing when the quotient is exhausted or the stack fills.
  assign div_end = (div_stat.quo == '0) || (cnt_r == CNT_W'(DIGIT_DEPTH - 1));

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_ch.value != '0)) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done && div_end) state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_ch.ready) begin
          state_nxt = (cnt_r == '0) ? S_IDLE : S_READ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs of the sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    div_start    = 1'b0;
    div_dividend = div_stat.quo;
    push         = 1'b0;
    pop          = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ch.ready  = 1'b1;
        div_dividend = in_ch.value;
        div_start    = in_ch.valid && (in_ch.value != '0);
      end
      S_DIV: begin
        push      = div_stat.done;
        // Chain the next division on the fresh quotient.
        div_start = div_stat.done && !div_end;
      end
      S_READ: begin
        pop = 1'b1;
      end
      S_EMIT: begin
        out_ch.valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push)     cnt_nxt = cnt_r + CNT_W'(1);
    else if (pop) cnt_nxt = cnt_dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Hold the clamped base for the whole item; on each pop, note whether it empties the stack.
  always_ff @(posedge clk) begin
    if (in_acc) base_r <= base_clamp(in_ch.base);
    if (pop)    last_r <= (cnt_dec == '0);
  end

  // Stack write on push, registered read on pop.
  always_ff @(posedge clk) begin
    if (push) stack_mem[cnt_r[IDX_W-1:0]] <= div_stat.rem;
    if (pop)  rd_data_r <= stack_mem[cnt_dec[IDX_W-1:0]];
  end

  assign out_ch.digit_char = to_ascii(rd_data_r);
  assign out_ch.last       = last_r;

  rdsc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (state_r == S_IDLE ? base_clamp(in_ch.base) : base_r),
    .stat     (div_stat)
  );

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r < CNT_W'(DIGIT_DEPTH))
    else $error("digit stack overflow");

  a_nonzero_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.value != '0) |=> state_r == S_DIV)
    else $error("nonzero item did not start dividing");

  a_last_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (last_r == (cnt_r == '0)))
    else $error("last flag disagrees with stack depth");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && last_r) |=> state_r == S_IDLE)
    else $error("item not finished after last character");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("pop of empty digit stack");

endmodule
